@@ rtl/core/ebsd_pkg.sv @@
// ----------------------------------------------------------------------------
// ebsd_pkg
// Shared widths, codes and types of the moving average baseline and spike block.
// ----------------------------------------------------------------------------
package ebsd_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int FLOOR_W  = 15;
    localparam int EXT_W    = SAMPLE_W + 1;
    localparam int PROD_W   = 2 * EXT_W;
    localparam int MAG_W    = PROD_W - 1;

    // lanes and sequencing
    localparam int LANES     = 4;
    localparam int LANE_W    = 2;
    localparam int MUL_STEPS = 2 * LANES;
    localparam int MSEL_W    = 3;
    localparam int DIV_STEPS = MAG_W;
    localparam int CNT_W     = 6;

    // stream and register port widths
    localparam int IN_TDATA_W  = 4 * SAMPLE_W;
    localparam int OUT_TDATA_W = 112;
    localparam int ADDR_W      = 3;

    // lane codes
    localparam logic [LANE_W-1:0] LANE_PM  = 2'd0;
    localparam logic [LANE_W-1:0] LANE_VOC = 2'd1;
    localparam logic [LANE_W-1:0] LANE_NOX = 2'd2;
    localparam logic [LANE_W-1:0] LANE_CO2 = 2'd3;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_ALPHA     = 3'd0;
    localparam logic [ADDR_W-1:0] REG_DIVISOR   = 3'd1;
    localparam logic [ADDR_W-1:0] REG_PM_FLOOR  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_VOC_FLOOR = 3'd3;
    localparam logic [ADDR_W-1:0] REG_NOX_FLOOR = 3'd4;

    // register reset values
    localparam logic [SAMPLE_W-1:0] ALPHA_RST   = 16'd1;
    localparam logic [SAMPLE_W-1:0] DIVISOR_RST = 16'd16;

    // controller states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_DINIT = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic              load;
        logic              mul_en;
        logic [MSEL_W-1:0] mul_sel;
        logic              div_init;
        logic              div_en;
        logic              fin;
    } cmd_t;

    // configuration register set
    typedef struct packed {
        logic [SAMPLE_W-1:0] alpha;
        logic [SAMPLE_W-1:0] divisor;
        logic [FLOOR_W-1:0]  pm_floor;
        logic [FLOOR_W-1:0]  voc_floor;
        logic [FLOOR_W-1:0]  nox_floor;
    } cfg_t;

    // one result word
    typedef struct packed {
        logic [SAMPLE_W-1:0] pm_baseline;
        logic [SAMPLE_W-1:0] voc_baseline;
        logic [SAMPLE_W-1:0] nox_baseline;
        logic [SAMPLE_W-1:0] co2_baseline;
        logic [FLOOR_W-1:0]  pm_spike;
        logic [FLOOR_W-1:0]  voc_spike_out;
        logic [FLOOR_W-1:0]  nox_spike_out;
    } result_t;

endpackage

@@ rtl/core/ebsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ebsd_ctrl
// Sequencer: eight shared multiply steps, drain, divider load, divide, finish.
// ----------------------------------------------------------------------------
module ebsd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_free,
    output ebsd_pkg::cmd_t cmd
);
    import ebsd_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cnt_reg[MSEL_W-1:0];
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_en = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // multiply phase never runs past its last step
    a_mul_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (cnt_reg < CNT_W'(MUL_STEPS)))
        else $error("multiply step count out of range");

    // a finish only happens when the output register can take it
    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> out_free)
        else $error("finish while output register busy");

    // an accepted word always starts the multiply phase at step zero
    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_MUL) && (cnt_reg == '0))
        else $error("load did not start multiply phase");

endmodule

@@ rtl/core/ebsd_dp.sv @@
// ----------------------------------------------------------------------------
// ebsd_dp
// Datapath: sample and baseline registers, shared multiplier, four restoring
// divider lanes, baseline update and spike clamp.
// ----------------------------------------------------------------------------
module ebsd_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ebsd_pkg::cmd_t                    cmd,
    input  ebsd_pkg::cfg_t                    cfg,
    input  logic [ebsd_pkg::IN_TDATA_W-1:0]   sample,
    input  logic                              co2_ok,
    output ebsd_pkg::result_t                 res
);
    import ebsd_pkg::*;

    logic [SAMPLE_W-1:0]      x_reg    [LANES];
    logic                     co2_ok_reg;
    logic [SAMPLE_W-1:0]      base_reg [LANES];
    logic signed [EXT_W-1:0]  x_ext    [LANES];
    logic signed [EXT_W-1:0]  base_ext [LANES];
    logic signed [EXT_W-1:0]  wgt_x;
    logic signed [EXT_W-1:0]  wgt_base;
    logic [LANE_W-1:0]        mul_lane;
    logic signed [EXT_W-1:0]  op_a;
    logic signed [EXT_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    logic [LANE_W-1:0]        prod_lane_reg;
    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] num_reg  [LANES];
    logic [PROD_W-1:0]        num_neg  [LANES];
    logic                     neg_reg  [LANES];
    logic [MAG_W-1:0]         dvd_reg  [LANES];
    logic [SAMPLE_W-1:0]      rem_reg  [LANES];
    logic [SAMPLE_W-1:0]      quo_reg  [LANES];
    logic [SAMPLE_W:0]        partial  [LANES];
    logic                     ge       [LANES];
    logic [SAMPLE_W:0]        part_sub [LANES];
    logic [SAMPLE_W-1:0]      quo_fix  [LANES];
    logic                     hold     [LANES];
    logic [SAMPLE_W-1:0]      new_base [LANES];
    logic [SAMPLE_W-1:0]      diff     [LANES-1];
    logic [FLOOR_W-1:0]       floor_v  [LANES-1];
    logic [FLOOR_W-1:0]       spike    [LANES-1];

    // sign or zero extension per lane
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if ((LANE_W'(l) == LANE_VOC) || (LANE_W'(l) == LANE_NOX))
            begin
                x_ext[l]    = {x_reg[l][SAMPLE_W-1], x_reg[l]};
                base_ext[l] = {base_reg[l][SAMPLE_W-1], base_reg[l]};
            end
            else
            begin
                x_ext[l]    = {1'b0, x_reg[l]};
                base_ext[l] = {1'b0, base_reg[l]};
            end
        end
    end

    // weights: alpha for the sample, divisor minus alpha for the baseline
    assign wgt_x    = {1'b0, cfg.alpha};
    assign wgt_base = {1'b0, cfg.divisor} - {1'b0, cfg.alpha};

    // shared multiplier operand select
    assign mul_lane = cmd.mul_sel[MSEL_W-1:1];
    assign op_a     = cmd.mul_sel[0] ? base_ext[mul_lane] : x_ext[mul_lane];
    assign op_b     = cmd.mul_sel[0] ? wgt_base : wgt_x;
    assign prod     = op_a * op_b;

    // product pipeline valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mul_en;
        end
    end

    // product register
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg      <= prod;
            prod_lane_reg <= mul_lane;
        end
    end

    // sample capture and numerator accumulation
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                x_reg[l]   <= sample[l*SAMPLE_W +: SAMPLE_W];
                num_reg[l] <= '0;
            end
            co2_ok_reg <= co2_ok;
        end
        else if (prod_vld_reg)
        begin
            num_reg[prod_lane_reg] <= num_reg[prod_lane_reg] + prod_reg;
        end
    end

    // divider step logic per lane
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            num_neg[l]  = -num_reg[l];
            partial[l]  = {rem_reg[l], dvd_reg[l][MAG_W-1]};
            ge[l]       = (partial[l] >= {1'b0, cfg.divisor});
            part_sub[l] = partial[l] - {1'b0, cfg.divisor};
        end
    end

    // restoring divider lanes, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (cmd.div_init)
            begin
                neg_reg[l] <= num_reg[l][PROD_W-1];
                dvd_reg[l] <= num_reg[l][PROD_W-1] ? num_neg[l][MAG_W-1:0]
                                                   : num_reg[l][MAG_W-1:0];
                rem_reg[l] <= '0;
            end
            else if (cmd.div_en)
            begin
                dvd_reg[l] <= {dvd_reg[l][MAG_W-2:0], 1'b0};
                rem_reg[l] <= ge[l] ? part_sub[l][SAMPLE_W-1:0]
                                    : partial[l][SAMPLE_W-1:0];
                quo_reg[l] <= {quo_reg[l][SAMPLE_W-2:0], ge[l]};
            end
        end
    end

    // signed quotient and baseline select
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo_fix[l]  = neg_reg[l] ? (~quo_reg[l] + 1'b1) : quo_reg[l];
            hold[l]     = (cfg.divisor == '0) ||
                          ((LANE_W'(l) == LANE_CO2) && !co2_ok_reg);
            new_base[l] = hold[l] ? base_reg[l] : quo_fix[l];
        end
    end

    // baseline state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                base_reg[l] <= '0;
            end
        end
        else if (cmd.fin)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                base_reg[l] <= new_base[l];
            end
        end
    end

    // spike: wrapped difference, clamp negatives and values under the floor
    assign floor_v[LANE_PM]  = cfg.pm_floor;
    assign floor_v[LANE_VOC] = cfg.voc_floor;
    assign floor_v[LANE_NOX] = cfg.nox_floor;

    always_comb
    begin
        for (int l = 0; l < LANES - 1; l++)
        begin
            diff[l] = x_reg[l] - new_base[l];
            if (diff[l][SAMPLE_W-1] || (diff[l][FLOOR_W-1:0] < floor_v[l]))
            begin
                spike[l] = '0;
            end
            else
            begin
                spike[l] = diff[l][FLOOR_W-1:0];
            end
        end
    end

    // result word
    assign res.pm_baseline   = new_base[LANE_PM];
    assign res.voc_baseline  = new_base[LANE_VOC];
    assign res.nox_baseline  = new_base[LANE_NOX];
    assign res.co2_baseline  = new_base[LANE_CO2];
    assign res.pm_spike      = spike[LANE_PM];
    assign res.voc_spike_out = spike[LANE_VOC];
    assign res.nox_spike_out = spike[LANE_NOX];

endmodule

@@ rtl/core/ema_baseline_spike_detector.sv @@
// ----------------------------------------------------------------------------
// ema_baseline_spike_detector
// Four moving average baselines with spike detection on air-quality samples.
// ----------------------------------------------------------------------------
// Sequence: after the input accept, 8 shared multiply steps, a drain, a
//   divider load, 33 divide steps and a finish, then output valid.
// A new word is taken only once the previous one has finished; the 33-step
//   restoring divider runs all four lanes together, and the next word is
//   taken while a result still waits in the output register.
// Reset: rst_n clears baselines to zero, registers to their defaults
//   (alpha 1, divisor 16, floors 0) and the output valid.
module ema_baseline_spike_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: pm_sample, voc_sample, nox_sample, co2_sample
    input  logic [ebsd_pkg::IN_TDATA_W-1:0]    s_tdata,
    // s_tuser: co2_ok
    input  logic                               s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata: pm_baseline, voc_baseline, nox_baseline, co2_baseline,
    //          pm_spike, voc_spike_out, nox_spike_out, zero pad
    output logic [ebsd_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  logic [ebsd_pkg::ADDR_W-1:0]        cfg_addr,
    input  logic [ebsd_pkg::SAMPLE_W-1:0]      cfg_wdata
);
    import ebsd_pkg::*;

    cfg_t                   cfg_reg;
    cmd_t                   cmd;
    result_t                res;
    logic                   out_free;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha     <= ALPHA_RST;
            cfg_reg.divisor   <= DIVISOR_RST;
            cfg_reg.pm_floor  <= '0;
            cfg_reg.voc_floor <= '0;
            cfg_reg.nox_floor <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ALPHA:     cfg_reg.alpha     <= cfg_wdata;
                REG_DIVISOR:   cfg_reg.divisor   <= cfg_wdata;
                REG_PM_FLOOR:  cfg_reg.pm_floor  <= cfg_wdata[FLOOR_W-1:0];
                REG_VOC_FLOOR: cfg_reg.voc_floor <= cfg_wdata[FLOOR_W-1:0];
                REG_NOX_FLOOR: cfg_reg.nox_floor <= cfg_wdata[FLOOR_W-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // controller
    ebsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .cmd      (cmd)
    );

    // datapath
    ebsd_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .sample (s_tdata),
        .co2_ok (s_tuser),
        .res    (res)
    );

    // output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.fin)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            m_tdata_reg <= {3'b000,
                            res.nox_spike_out, res.voc_spike_out, res.pm_spike,
                            res.co2_baseline, res.nox_baseline,
                            res.voc_baseline, res.pm_baseline};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
